### rtl/tone_queue_player_core_assert.svh
// assertion macros for the tone queue player core
// expects aclk and aresetn in the scope of the module that uses them
`ifndef TONE_QUEUE_PLAYER_CORE_ASSERT_SVH
`define TONE_QUEUE_PLAYER_CORE_ASSERT_SVH

// same-cycle implication
`define TQP_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tone queue player check failed");

// next-cycle implication
`define TQP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tone queue player check failed");

`endif

### rtl/tqp_pkg.sv
// shared types, constants and helpers for the tone queue player core
// no dependencies
`default_nettype none

package tqp_pkg;

    localparam int unsigned QUEUE_DEPTH = 256;
    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;
    localparam int unsigned CNT_EXT_W = PTR_W + 9;

    localparam int unsigned KIND_W = 2;
    localparam int unsigned FREQ_W = 16;
    localparam int unsigned DUR_W = 16;
    localparam int unsigned TPS_W = 20;
    localparam int unsigned QCOUNT_W = 8;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned ENTRY_W = FREQ_W + DUR_W;

    localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [TPS_W-1:0] TPS_RESET = 20'd91;
    localparam int unsigned MS_PER_SECOND = 1000;
    localparam int unsigned COUNT_SAT = 255;

    // tps / 1000 by reciprocal, quotient low by at most one
    localparam int unsigned RECIP_TPS_SHIFT = 30;
    localparam int unsigned RECIP_TPS_W = 21;
    localparam logic [RECIP_TPS_W-1:0] RECIP_TPS =
        RECIP_TPS_W'((64'd1 << RECIP_TPS_SHIFT) / MS_PER_SECOND);
    localparam int unsigned TPS_PROD_W = TPS_W + RECIP_TPS_W;
    localparam int unsigned TPS_Q_W = TPS_PROD_W - RECIP_TPS_SHIFT;
    localparam int unsigned TPS_R_W = 10;

    // (dur * remainder) / 1000 by reciprocal
    localparam int unsigned Y_W = DUR_W + TPS_R_W;
    localparam int unsigned Z_W = DUR_W + TPS_Q_W;
    localparam int unsigned RECIP_MS_SHIFT = 36;
    localparam int unsigned RECIP_MS_W = 27;
    localparam logic [RECIP_MS_W-1:0] RECIP_MS =
        RECIP_MS_W'((64'd1 << RECIP_MS_SHIFT) / MS_PER_SECOND);
    localparam int unsigned Y_PROD_W = Y_W + RECIP_MS_W;
    localparam int unsigned YQ_W = Y_PROD_W - RECIP_MS_SHIFT;

    typedef struct packed {
        logic take;
        logic split;
        logic mul;
        logic quot;
        logic fix;
        logic load_end;
        logic out_load;
    } tqp_cmd_t;

    typedef struct packed {
        logic start_needed;
    } tqp_status_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/tqp_datapath.sv
// note ring, timing state, duration-to-ticks arithmetic and result register
// depends on tqp_pkg and tone_queue_player_core_assert.svh
`default_nettype none
`include "tone_queue_player_core_assert.svh"

module tqp_datapath
    import tqp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tqp_cmd_t             cmd,
    output tqp_status_t               status,
    input  wire logic [KIND_W-1:0]    kind,
    input  wire logic [FREQ_W-1:0]    note_freq,
    input  wire logic [DUR_W-1:0]     note_duration,
    input  wire logic                 cfg_write,
    input  wire logic [TPS_W-1:0]     cfg_data,
    output logic [FREQ_W-1:0]         tone_freq,
    output logic                      sounding,
    output logic [QCOUNT_W-1:0]       queue_count,
    output logic                      dropped,
    output logic                      note_done
);

    logic [ENTRY_W-1:0] note_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [TIME_W-1:0] tick_cnt_reg, tick_cnt_next;
    logic [TIME_W-1:0] end_time_reg, end_time_next;
    logic              playing_reg, playing_next;
    logic [FREQ_W-1:0] cur_freq_reg, cur_freq_next;
    logic [TPS_W-1:0]  tps_reg, tps_next;
    logic              dropped_reg, dropped_next;
    logic              done_reg, done_next;
    logic [TIME_W-1:0] base_reg, base_next;

    logic [TPS_Q_W-1:0] qa_reg;
    logic [TPS_Q_W-1:0] a_reg;
    logic [TPS_R_W-1:0] b_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic [Y_W-1:0]     y_reg;
    logic [Z_W-1:0]     z_reg;
    logic [YQ_W-1:0]    qy_reg;
    logic [YQ_W-1:0]    qf_reg;

    logic [FREQ_W-1:0]   out_freq_reg;
    logic                out_sounding_reg;
    logic [QCOUNT_W-1:0] out_count_reg;
    logic                out_dropped_reg;
    logic                out_done_reg;

    logic [CNT_W-1:0]     count;
    logic [CNT_EXT_W-1:0] count_ext;
    logic                 full;
    logic                 do_write;
    logic [TIME_W-1:0]    tick_inc;
    logic [TIME_W-1:0]    time_diff;
    logic [PTR_W-1:0]     rd_adv;
    logic                 start;

    logic [TPS_PROD_W-1:0] tps_prod;
    logic [TPS_PROD_W-1:0] ra;
    logic                  ra_ge;
    logic [Y_PROD_W-1:0]   y_prod;
    logic [Z_W-1:0]        ry;

    // occupancy
    always_comb begin
        if (wr_ptr_reg >= rd_ptr_reg) begin
            count = CNT_W'(wr_ptr_reg) - CNT_W'(rd_ptr_reg);
        end else begin
            count = CNT_W'(QUEUE_DEPTH) - CNT_W'(rd_ptr_reg) + CNT_W'(wr_ptr_reg);
        end
        count_ext = CNT_EXT_W'(count);
        full = (count >= CNT_W'(QUEUE_DEPTH - 1));
    end

    assign tick_inc = tick_cnt_reg + 1'b1;
    assign time_diff = tick_inc - end_time_reg;
    assign rd_adv = ring_next(rd_ptr_reg);

    // item decode
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        tick_cnt_next = tick_cnt_reg;
        playing_next = playing_reg;
        cur_freq_next = cur_freq_reg;
        dropped_next = 1'b0;
        done_next = 1'b0;
        base_next = tick_inc;
        start = 1'b0;
        do_write = 1'b0;
        case (kind)
            KIND_ENQUEUE: begin
                if (full) begin
                    dropped_next = 1'b1;
                end else begin
                    do_write = 1'b1;
                    wr_ptr_next = ring_next(wr_ptr_reg);
                end
            end
            KIND_TICK: begin
                tick_cnt_next = tick_inc;
                if (playing_reg) begin
                    if (!time_diff[TIME_W-1]) begin
                        done_next = 1'b1;
                        playing_next = 1'b0;
                        cur_freq_next = '0;
                        rd_ptr_next = rd_adv;
                        base_next = end_time_reg;
                        start = (rd_adv != wr_ptr_reg);
                    end
                end else begin
                    start = (rd_ptr_reg != wr_ptr_reg);
                end
            end
            KIND_CLEAR: begin
                rd_ptr_next = wr_ptr_reg;
                playing_next = 1'b0;
                cur_freq_next = '0;
            end
            default: begin
            end
        endcase
    end

    assign status.start_needed = start;

    // duration to ticks
    assign tps_prod = TPS_PROD_W'(tps_reg) * TPS_PROD_W'(RECIP_TPS);
    assign ra = TPS_PROD_W'(tps_reg) - TPS_PROD_W'(qa_reg) * TPS_PROD_W'(MS_PER_SECOND);
    assign ra_ge = (ra >= TPS_PROD_W'(MS_PER_SECOND));
    assign y_prod = Y_PROD_W'(y_reg) * Y_PROD_W'(RECIP_MS);
    assign ry = Z_W'(y_reg) - Z_W'(qy_reg) * Z_W'(MS_PER_SECOND);

    assign tps_next = cfg_write ? cfg_data : tps_reg;
    assign end_time_next = base_reg + TIME_W'(z_reg) + TIME_W'(qf_reg);

    always_ff @(posedge aclk) begin
        if (do_write && cmd.take) begin
            note_mem[wr_ptr_reg] <= {note_freq, note_duration};
        end
        rdata_reg <= note_mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            tick_cnt_reg <= '0;
            end_time_reg <= '0;
            playing_reg <= 1'b0;
            cur_freq_reg <= '0;
            tps_reg <= TPS_RESET;
            dropped_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            tps_reg <= tps_next;
            if (cmd.take) begin
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
                tick_cnt_reg <= tick_cnt_next;
                playing_reg <= playing_next;
                cur_freq_reg <= cur_freq_next;
                dropped_reg <= dropped_next;
                done_reg <= done_next;
            end
            if (cmd.load_end) begin
                end_time_reg <= end_time_next;
                playing_reg <= 1'b1;
                cur_freq_reg <= freq_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            base_reg <= base_next;
        end
        qa_reg <= tps_prod[TPS_PROD_W-1:RECIP_TPS_SHIFT];
        if (cmd.split) begin
            a_reg <= ra_ge ? qa_reg + 1'b1 : qa_reg;
            b_reg <= ra_ge ? TPS_R_W'(ra - TPS_PROD_W'(MS_PER_SECOND)) : TPS_R_W'(ra);
            dur_reg <= rdata_reg[DUR_W-1:0];
            freq_reg <= rdata_reg[ENTRY_W-1:DUR_W];
        end
        if (cmd.mul) begin
            y_reg <= Y_W'(dur_reg) * Y_W'(b_reg);
            z_reg <= Z_W'(dur_reg) * Z_W'(a_reg);
        end
        if (cmd.quot) begin
            qy_reg <= y_prod[Y_PROD_W-1:RECIP_MS_SHIFT];
        end
        if (cmd.fix) begin
            qf_reg <= (ry >= Z_W'(MS_PER_SECOND)) ? qy_reg + 1'b1 : qy_reg;
        end
        if (cmd.out_load) begin
            out_freq_reg <= cur_freq_reg;
            out_sounding_reg <= playing_reg;
            out_count_reg <= (count_ext > CNT_EXT_W'(COUNT_SAT)) ?
                             QCOUNT_W'(COUNT_SAT) : QCOUNT_W'(count_ext);
            out_dropped_reg <= dropped_reg;
            out_done_reg <= done_reg;
        end
    end

    assign tone_freq = out_freq_reg;
    assign sounding = out_sounding_reg;
    assign queue_count = out_count_reg;
    assign dropped = out_dropped_reg;
    assign note_done = out_done_reg;

    `TQP_ASSERT_NEXT(a_full_drop_keeps_tail, cmd.take && kind == KIND_ENQUEUE && full, $stable(wr_ptr_reg) && dropped_reg)
    `TQP_ASSERT_NEXT(a_clear_empties, cmd.take && kind == KIND_CLEAR, rd_ptr_reg == wr_ptr_reg && !playing_reg && cur_freq_reg == '0)
    `TQP_ASSERT_NEXT(a_end_load_plays, cmd.load_end, playing_reg && $stable(rd_ptr_reg))

endmodule

`default_nettype wire

### rtl/tqp_controller.sv
// sequencing state machine and result valid for the tone queue player core
// depends on tqp_pkg and tone_queue_player_core_assert.svh
`default_nettype none
`include "tone_queue_player_core_assert.svh"

module tqp_controller
    import tqp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire tqp_status_t status,
    output tqp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SPLIT,
        S_MUL,
        S_QUOT,
        S_FIX,
        S_END,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd = '0;
        cmd.take = (state_reg == S_IDLE) && s_valid;
        cmd.split = (state_reg == S_SPLIT);
        cmd.mul = (state_reg == S_MUL);
        cmd.quot = (state_reg == S_QUOT);
        cmd.fix = (state_reg == S_FIX);
        cmd.load_end = (state_reg == S_END);
        cmd.out_load = (state_reg == S_RESULT) && slot_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = status.start_needed ? S_READ : S_RESULT;
                end
            end
            S_READ:   state_next = S_SPLIT;
            S_SPLIT:  state_next = S_MUL;
            S_MUL:    state_next = S_QUOT;
            S_QUOT:   state_next = S_FIX;
            S_FIX:    state_next = S_END;
            S_END:    state_next = S_RESULT;
            S_RESULT: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
        m_valid_next = cmd.out_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    `TQP_ASSERT_NEXT(a_start_reads, s_valid && s_ready && status.start_needed, state_reg == S_READ)
    `TQP_ASSERT_NEXT(a_plain_item_result, s_valid && s_ready && !status.start_needed, state_reg == S_RESULT)
    `TQP_ASSERT_NEXT(a_result_returns, state_reg == S_RESULT && (!m_valid_reg || m_ready), state_reg == S_IDLE && m_valid_reg)

endmodule

`default_nettype wire

### rtl/tone_queue_player_core.sv
// top level of the tone queue player core: controller plus datapath
// depends on tqp_pkg, tqp_controller and tqp_datapath
//
// channel   direction  handshake             payload
// s_        in         s_valid / s_ready     kind, note_freq, note_duration
// m_        out        m_valid / m_ready     tone_freq, sounding, queue_count, dropped, note_done
// cfg_      in         cfg_valid / cfg_ready ticks_per_second (cfg_data)
//
// enqueue, clear and ticks that start no note go straight to the result register
// a tick that starts a note first passes through the ring read and the
// reciprocal multiply steps that turn milliseconds into ticks
// one request in flight at a time; the result register frees the input
// side while a result waits for m_ready
// no clearing pass after reset; cfg_ready is always high
`default_nettype none

module tone_queue_player_core
    import tqp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [KIND_W-1:0]   s_kind,
    input  wire logic [FREQ_W-1:0]   s_note_freq,
    input  wire logic [DUR_W-1:0]    s_note_duration,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [FREQ_W-1:0]        m_tone_freq,
    output logic                     m_sounding,
    output logic [QCOUNT_W-1:0]      m_queue_count,
    output logic                     m_dropped,
    output logic                     m_note_done,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [TPS_W-1:0]    cfg_data
);

    tqp_cmd_t    cmd;
    tqp_status_t status;

    assign cfg_ready = 1'b1;

    tqp_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tqp_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .kind          (s_kind),
        .note_freq     (s_note_freq),
        .note_duration (s_note_duration),
        .cfg_write     (cfg_valid),
        .cfg_data      (cfg_data),
        .tone_freq     (m_tone_freq),
        .sounding      (m_sounding),
        .queue_count   (m_queue_count),
        .dropped       (m_dropped),
        .note_done     (m_note_done)
    );

endmodule

`default_nettype wire

### test/tb.sv
// testbench for tone_queue_player_core: random and directed note, tick and clear requests
// checked against a cycle-free player model; depends on tqp_pkg and the core rtl
`timescale 1ns / 1ps

module tb
    import tqp_pkg::*;
();

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

    typedef struct {
        logic              is_cfg;
        logic [KIND_W-1:0] kind;
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
        logic [TPS_W-1:0]  tps;
        pace_t             pace;
    } request_t;

    typedef struct packed {
        logic [FREQ_W-1:0]   tone_freq;
        logic                sounding;
        logic [QCOUNT_W-1:0] queue_count;
        logic                dropped;
        logic                note_done;
    } player_status_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind = '0;
    logic [FREQ_W-1:0]   s_note_freq = '0;
    logic [DUR_W-1:0]    s_note_duration = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [FREQ_W-1:0]   m_tone_freq;
    logic                m_sounding;
    logic [QCOUNT_W-1:0] m_queue_count;
    logic                m_dropped;
    logic                m_note_done;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [TPS_W-1:0]    cfg_data = TPS_RESET;

    tone_queue_player_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_note_freq     (s_note_freq),
        .s_note_duration (s_note_duration),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tone_freq     (m_tone_freq),
        .m_sounding      (m_sounding),
        .m_queue_count   (m_queue_count),
        .m_dropped       (m_dropped),
        .m_note_done     (m_note_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // player model state
    logic [FREQ_W-1:0] held_freq [QUEUE_DEPTH];
    logic [DUR_W-1:0]  held_dur [QUEUE_DEPTH];
    logic [PTR_W-1:0]  ring_rd = '0;
    logic [PTR_W-1:0]  ring_wr = '0;
    logic [TIME_W-1:0] tick_now = '0;
    logic [TIME_W-1:0] note_end = '0;
    logic              playing_now = 1'b0;
    logic [FREQ_W-1:0] tone_now = '0;
    logic [TPS_W-1:0]  tps_now = TPS_RESET;

    request_t       pending [$];
    player_status_t status_expected [$];
    pace_t          pace = PACE_SLOW_SINK;
    pace_t          gen_pace = PACE_SLOW_SINK;
    int unsigned    gen_tps = 32'(TPS_RESET);

    int error_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int notes_finished = 0;
    int drops_seen = 0;
    int settings_applied = 0;
    int cycle_count = 0;

    function automatic logic [PTR_W-1:0] slot_after(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic int unsigned notes_held();
        if (ring_wr >= ring_rd) begin
            return 32'(ring_wr - ring_rd);
        end
        return QUEUE_DEPTH - 32'(ring_rd) + 32'(ring_wr);
    endfunction

    task automatic start_note(input logic [TIME_W-1:0] base);
        logic [63:0] span;
        span = (64'(held_dur[ring_rd]) * 64'(tps_now)) / 64'(MS_PER_SECOND);
        note_end = base + TIME_W'(span);
        tone_now = held_freq[ring_rd];
        playing_now = 1'b1;
    endtask

    task automatic predict_step(input logic [KIND_W-1:0] kind, input logic [FREQ_W-1:0] freq,
                                input logic [DUR_W-1:0] dur);
        player_status_t want;
        logic [TIME_W-1:0] lag;
        logic [TIME_W-1:0] base;
        int unsigned held;
        want = '0;
        case (kind)
            KIND_ENQUEUE: begin
                if (notes_held() >= QUEUE_DEPTH - 1) begin
                    want.dropped = 1'b1;
                end else begin
                    held_freq[ring_wr] = freq;
                    held_dur[ring_wr] = dur;
                    ring_wr = slot_after(ring_wr);
                end
            end
            KIND_TICK: begin
                tick_now = tick_now + 1'b1;
                if (playing_now) begin
                    lag = tick_now - note_end;
                    // wrap-aware: the end time has been reached
                    if (!lag[TIME_W-1]) begin
                        base = note_end;
                        want.note_done = 1'b1;
                        playing_now = 1'b0;
                        tone_now = '0;
                        ring_rd = slot_after(ring_rd);
                        if (ring_rd != ring_wr) begin
                            start_note(base);
                        end
                    end
                end else if (ring_rd != ring_wr) begin
                    start_note(tick_now);
                end
            end
            KIND_CLEAR: begin
                ring_rd = ring_wr;
                playing_now = 1'b0;
                tone_now = '0;
            end
            default: begin
            end
        endcase
        held = notes_held();
        want.tone_freq = tone_now;
        want.sounding = playing_now;
        want.queue_count = (held > COUNT_SAT) ? QCOUNT_W'(COUNT_SAT) : QCOUNT_W'(held);
        status_expected.push_back(want);
    endtask

    task automatic note_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("%0t mismatch at result %0d: %s got 0x%0h want 0x%0h",
                 $time, results_seen, what, got, want);
    endtask

    task automatic push_item(input logic [KIND_W-1:0] kind, input logic [FREQ_W-1:0] freq,
                             input logic [DUR_W-1:0] dur);
        request_t req;
        req.is_cfg = 1'b0;
        req.kind = kind;
        req.freq = freq;
        req.dur = dur;
        req.tps = '0;
        req.pace = gen_pace;
        pending.push_back(req);
    endtask

    task automatic push_setting(input logic [TPS_W-1:0] tps);
        request_t req;
        req.is_cfg = 1'b1;
        req.kind = KIND_UNUSED;
        req.freq = '0;
        req.dur = '0;
        req.tps = tps;
        req.pace = gen_pace;
        pending.push_back(req);
        gen_tps = 32'(tps);
    endtask

    task automatic push_random(input int n);
        int made;
        int pick;
        int unsigned dmax;
        logic [FREQ_W-1:0] f;
        logic [DUR_W-1:0] d;
        // mostly durations of a few ticks so notes finish and chain
        dmax = (gen_tps == 0) ? 65535 : 6000 / gen_tps;
        if (dmax > 65535) begin
            dmax = 65535;
        end
        made = 0;
        while (made < n) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                push_item(KIND_UNUSED, FREQ_W'($urandom), DUR_W'($urandom));
            end else begin
                made++;
                if (pick < 9) begin
                    push_item(KIND_CLEAR, FREQ_W'($urandom), DUR_W'($urandom));
                end else if (pick < 45) begin
                    f = ($urandom_range(4) == 0) ? '0 : FREQ_W'($urandom);
                    d = ($urandom_range(3) == 0) ? DUR_W'($urandom) :
                                                   DUR_W'($urandom_range(dmax, 0));
                    push_item(KIND_ENQUEUE, f, d);
                end else begin
                    push_item(KIND_TICK, FREQ_W'($urandom), DUR_W'($urandom));
                end
            end
        end
    endtask

    always @(posedge aclk) begin : driver
        request_t req;
        logic s_hold;
        logic c_hold;
        logic s_next;
        logic c_next;
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_step(s_kind, s_note_freq, s_note_duration);
                items_sent++;
            end
            if (cfg_valid && cfg_ready) begin
                tps_now = cfg_data;
                settings_applied++;
            end
            s_hold = s_valid && !s_ready;
            c_hold = cfg_valid && !cfg_ready;
            s_next = s_hold;
            c_next = c_hold;
            if (!s_hold && !c_hold && pending.size() > 0) begin
                req = pending[0];
                pace <= req.pace;
                if (req.is_cfg) begin
                    // rate change only once every request has its result
                    if (status_expected.size() == 0 && !s_valid) begin
                        req = pending.pop_front();
                        c_next = 1'b1;
                        cfg_data <= req.tps;
                    end
                end else if ($urandom_range(99) >= ((req.pace == PACE_SLOW_SINK) ? 10 :
                                                    (req.pace == PACE_SLOW_SOURCE) ? 66 : 0)) begin
                    req = pending.pop_front();
                    s_next = 1'b1;
                    s_kind <= req.kind;
                    s_note_freq <= req.freq;
                    s_note_duration <= req.dur;
                end
            end
            s_valid <= s_next;
            cfg_valid <= c_next;
        end
    end

    always @(posedge aclk) begin : monitor
        player_status_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (status_expected.size() == 0) begin
                    note_mismatch("result with no request waiting", 0, 0);
                end else begin
                    want = status_expected.pop_front();
                    if (m_tone_freq !== want.tone_freq) begin
                        note_mismatch("tone_freq", 64'(m_tone_freq), 64'(want.tone_freq));
                    end
                    if (m_sounding !== want.sounding) begin
                        note_mismatch("sounding", 64'(m_sounding), 64'(want.sounding));
                    end
                    if (m_queue_count !== want.queue_count) begin
                        note_mismatch("queue_count", 64'(m_queue_count),
                                      64'(want.queue_count));
                    end
                    if (m_dropped !== want.dropped) begin
                        note_mismatch("dropped", 64'(m_dropped), 64'(want.dropped));
                    end
                    if (m_note_done !== want.note_done) begin
                        note_mismatch("note_done", 64'(m_note_done), 64'(want.note_done));
                    end
                    notes_finished += want.note_done;
                    drops_seen += want.dropped;
                end
                results_seen++;
            end
            m_ready <= ($urandom_range(99) >= ((pace == PACE_SLOW_SINK) ? 66 :
                                               (pace == PACE_SLOW_SOURCE) ? 10 : 0));
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[tone_queue_player_core] ERROR");
            $finish;
        end
    end

    initial begin
        int i;

        // directed requests at the reset tick rate of 91 per second
        gen_pace = PACE_SLOW_SINK;
        push_item(KIND_TICK, '0, '0);
        push_item(KIND_UNUSED, 16'hffff, 16'hffff);
        push_item(KIND_ENQUEUE, 16'hffff, 16'hffff);
        push_item(KIND_ENQUEUE, 16'd0, 16'd22);
        push_item(KIND_ENQUEUE, 16'd1, 16'd0);
        push_item(KIND_TICK, 16'hffff, 16'hffff);
        push_item(KIND_CLEAR, 16'hffff, 16'hffff);
        push_item(KIND_ENQUEUE, 16'd440, 16'd11);
        push_item(KIND_ENQUEUE, 16'd0, 16'd22);
        push_item(KIND_ENQUEUE, 16'd1, 16'd0);
        push_item(KIND_ENQUEUE, 16'hffff, 16'd0);
        for (i = 0; i < 7; i++) begin
            push_item(KIND_TICK, '0, '0);
        end
        push_item(KIND_CLEAR, '0, '0);
        push_item(KIND_TICK, '0, '0);

        push_setting(TPS_W'(1000));
        push_random(170);
        push_setting(TPS_W'(1));
        push_random(170);

        // zero-length notes; fill the ring past full, then drain a little
        gen_pace = PACE_SLOW_SOURCE;
        push_setting('0);
        push_item(KIND_CLEAR, '0, '0);
        for (i = 0; i < QUEUE_DEPTH + 1; i++) begin
            push_item(KIND_ENQUEUE, FREQ_W'($urandom), DUR_W'($urandom));
        end
        for (i = 0; i < 6; i++) begin
            push_item(KIND_TICK, '0, '0);
        end
        push_random(40);
        push_setting(TPS_W'(1000000));
        push_random(150);
        push_setting('1);
        push_random(100);

        gen_pace = PACE_FULL;
        push_setting(TPS_W'(333));
        push_random(170);
        push_setting('0);
        push_random(120);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() > 0 || s_valid || cfg_valid || status_expected.size() > 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);

        $display("%0d requests, %0d tick-rate changes, %0d results checked", items_sent,
                 settings_applied, results_seen);
        $display("%0d notes finished, %0d enqueues refused on a full ring", notes_finished,
                 drops_seen);
        if (error_count == 0) begin
            $display("[tone_queue_player_core] OK");
        end else begin
            $display("[tone_queue_player_core] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tqp_pkg.sv
rtl/tqp_datapath.sv
rtl/tqp_controller.sv
rtl/tone_queue_player_core.sv
test/tb.sv
